/* src/efd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped frame deframer package
// Shared types, register indexes, reset values and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package efd_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_HEAD   = 2'd0;
	localparam logic [1:0] CFG_TAIL   = 2'd1;
	localparam logic [1:0] CFG_ESCAPE = 2'd2;

	// Reset values of the configuration registers
	localparam logic [7:0] HEAD_RESET   = 8'hAA;
	localparam logic [7:0] TAIL_RESET   = 8'h55;
	localparam logic [7:0] ESCAPE_RESET = 8'hCC;

	// CRC-16/MODBUS constants
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Saturation point of the literal counter
	localparam logic [8:0] COUNT_MAX = 9'd511;

	// Result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_LENGTH = 2'd1;
	localparam logic [1:0] STAT_CRC    = 2'd2;

	// Framing configuration as seen by the decoder
	typedef struct packed {
		logic [7:0] head_char;
		logic [7:0] tail_char;
		logic [7:0] escape_char;
	} cfg_t;

	// One result word
	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [1:0] status;
		logic [7:0] length;
	} res_t;

	// Frame tracking state
	typedef enum logic [1:0] {
		ST_HUNT  = 2'b01,
		ST_FRAME = 2'b10
	} state_t;

	// Reflected CRC-16 update over one byte, eight shift steps.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* src/escaped_frame_deframer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped frame deframer
// Strips byte-stuffed framing from a link byte stream and checks each frame.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_byte) takes one raw link word per
// cycle while in_ready is high. Each word passes an input register, then the
// decode core, then an output register.
// The output channel (out_valid, out_ready, out_kind, out_byte, out_status,
// out_length) gives payload data and a status word per frame tail or abort.
// Throughput is one word per cycle while no stall holds it, set by the state
// update of the decode core, which includes the eight-step CRC byte update.
// When the receiver stalls, the output register holds its word and the
// input register holds the next one; in_ready drops until out_ready returns.
// The config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready and should be written only while no word is in flight.
// Reset hunts for a head byte with the default head, tail and escape values
// and leaves both registers empty.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_unit
	import efd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_kind,
	output logic [7:0] out_byte,
	output logic [1:0] out_status,
	output logic [7:0] out_length,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       res_valid;
	res_t       res;
	logic       out_valid_q;
	res_t       out_q;

	assign cfg_ready = 1'b1;

	efd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The held word moves on when the output register is free or draining.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	efd_decoder u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.in_byte   (byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_q.kind;
	assign out_byte   = out_q.data;
	assign out_status = out_q.status;
	assign out_length = out_q.length;

endmodule

/* src/efd_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Holds the head, tail and escape byte values written over the config port.
// ----------------------------------------------------------------------------
module efd_cfg_regs
	import efd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [7:0] wr_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	// Register write; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_char   <= HEAD_RESET;
			cfg_q.tail_char   <= TAIL_RESET;
			cfg_q.escape_char <= ESCAPE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_HEAD:   cfg_q.head_char   <= wr_data;
				CFG_TAIL:   cfg_q.tail_char   <= wr_data;
				CFG_ESCAPE: cfg_q.escape_char <= wr_data;
				default:    ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/efd_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer decode core
// Frame state, unescaping, field capture, CRC accumulation and result build.
// ----------------------------------------------------------------------------
module efd_decoder
	import efd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] in_byte,
	input  cfg_t       cfg,
	output logic       res_valid,
	output res_t       res
);

	state_t      state_q, state_d;
	logic        prev_esc_q, prev_esc_d;
	logic [7:0]  length_q, length_d;
	logic [7:0]  command_q, command_d;
	logic [7:0]  held_q, held_d;
	logic [8:0]  count_q, count_d;
	logic [15:0] crc_q, crc_d;

	logic        is_head, is_tail, is_esc;
	logic        lit_ok, length_bad;
	logic [7:0]  lit;
	logic [7:0]  status_len;
	logic [15:0] crc_in;
	logic [7:0]  crc_src;

	assign is_head = (in_byte == cfg.head_char);
	assign is_tail = (in_byte == cfg.tail_char);
	assign is_esc  = (in_byte == cfg.escape_char);

	// Status length field and the frame length check
	assign status_len = (length_q != 8'd0) ? (length_q - 8'd1) : 8'd0;
	assign length_bad = (length_q == 8'd0) || (count_q != ({1'b0, length_q} + 9'd2));

	// The CRC takes the first two literals directly, later the held byte.
	assign crc_src = (count_q < 9'd2) ? lit : held_q;
	assign crc_in  = crc16_byte(crc_q, crc_src);

	// Next state and result for one byte
	always_comb begin
		state_d    = state_q;
		prev_esc_d = prev_esc_q;
		length_d   = length_q;
		command_d  = command_q;
		held_d     = held_q;
		count_d    = count_q;
		crc_d      = crc_q;
		res_valid  = 1'b0;
		res        = '{kind: KIND_DATA, data: held_q, status: STAT_OK, length: 8'd0};
		lit_ok     = 1'b0;
		lit        = in_byte;

		if (step) begin
			if (state_q == ST_HUNT) begin
				if (is_head && !prev_esc_q) begin
					state_d    = ST_FRAME;
					prev_esc_d = 1'b0;
					length_d   = 8'd0;
					command_d  = 8'd0;
					held_d     = 8'd0;
					count_d    = 9'd0;
					crc_d      = CRC_INIT;
				end else begin
					prev_esc_d = is_esc;
				end
			end else if (is_head) begin
				// Head inside a frame aborts it and reopens at once.
				res_valid  = 1'b1;
				res        = '{kind: KIND_STATUS, data: command_q, status: STAT_LENGTH,
					length: status_len};
				prev_esc_d = 1'b0;
				length_d   = 8'd0;
				command_d  = 8'd0;
				held_d     = 8'd0;
				count_d    = 9'd0;
				crc_d      = CRC_INIT;
			end else if (is_tail) begin
				res_valid = 1'b1;
				res.kind  = KIND_STATUS;
				res.data  = command_q;
				res.length = status_len;
				if (length_bad) begin
					res.status = STAT_LENGTH;
				end else if (held_q != crc_q[7:0]) begin
					res.status = STAT_CRC;
				end else begin
					res.status = STAT_OK;
				end
				state_d    = ST_HUNT;
				prev_esc_d = 1'b0;
			end else if (prev_esc_q) begin
				lit        = in_byte - 8'd1;
				lit_ok     = 1'b1;
				prev_esc_d = 1'b0;
			end else if (is_esc) begin
				prev_esc_d = 1'b1;
			end else begin
				lit_ok = 1'b1;
			end

			// Literal capture: length, command, then delayed data.
			if (lit_ok) begin
				if (count_q == 9'd0) begin
					length_d = lit;
					crc_d    = crc_in;
				end else if (count_q == 9'd1) begin
					command_d = lit;
					crc_d     = crc_in;
				end else begin
					if (count_q >= 9'd3) begin
						res_valid = 1'b1;
						crc_d     = crc_in;
					end
					held_d = lit;
				end
				if (count_q < COUNT_MAX) begin
					count_d = count_q + 9'd1;
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_HUNT;
			prev_esc_q <= 1'b0;
			length_q   <= 8'd0;
			command_q  <= 8'd0;
			held_q     <= 8'd0;
			count_q    <= 9'd0;
			crc_q      <= CRC_INIT;
		end else begin
			state_q    <= state_d;
			prev_esc_q <= prev_esc_d;
			length_q   <= length_d;
			command_q  <= command_d;
			held_q     <= held_d;
			count_q    <= count_d;
			crc_q      <= crc_d;
		end
	end

endmodule
